>>> rtl/tpr_pkg.sv
// Shared types, constants and helper functions of the ternary tile pixel renderer.
package tpr_pkg;

  // Screen geometry.
  localparam int GRID_COLUMNS = 32;
  localparam int GRID_ROWS    = 32;
  localparam int TRIT_PIXELS  = 1;
  localparam int GRID_CELLS   = GRID_COLUMNS * GRID_ROWS;

  // Tile and digit geometry.
  localparam int TILE_COUNT   = 729;
  localparam int TILE_ROWS    = 9;
  localparam int TILE_TRITS   = 9;
  localparam int DIGIT_BASE   = 27;
  localparam int DIGIT_MAX    = 13;
  localparam int PAL_TRITS    = 3;
  localparam int PAT_MID_STEP = DIGIT_BASE * TILE_ROWS;

  // Store depths and address widths.
  localparam int PAT_DEPTH  = TILE_COUNT * TILE_ROWS;
  localparam int GRID_DEPTH = 1024;
  localparam int PAL_DEPTH  = 81;
  localparam int PAT_AW     = $clog2(PAT_DEPTH);
  localparam int GRID_AW    = $clog2(GRID_DEPTH);
  localparam int PAL_AW     = $clog2(PAL_DEPTH);

  // Field widths.
  localparam int CMD_W       = 2;
  localparam int TILE_W      = 10;
  localparam int PROW_W      = 4;
  localparam int ROW_W       = 18;
  localparam int DIGIT_W     = 5;
  localparam int CELL_DATA_W = 3 * DIGIT_W;
  localparam int CHAN_W      = 8;
  localparam int COLOR_W     = 3 * CHAN_W;
  localparam int XY_W        = 9;
  localparam int TRIT_IDX_W  = 4;

  // Pattern row with every trit at zero (code 1 in each pair).
  localparam logic [ROW_W-1:0] ROW_ALL_ZERO = 18'h15555;

  // Pixel to grid cell: divide by the tile width through a reciprocal.
  localparam int TILE_PX    = TILE_TRITS * TRIT_PIXELS;
  localparam int GX_W       = $clog2((2 ** XY_W - 1) / TILE_PX + 1);
  localparam int COL_W      = $clog2(GRID_COLUMNS + 1);
  localparam int CELL_W_RAW = GX_W + COL_W + 1;
  localparam int CELL_W     = (CELL_W_RAW > GRID_AW) ? CELL_W_RAW : GRID_AW;
  localparam int PX_W       = $clog2(TILE_PX);
  localparam int RECIP_SH   = 16;
  localparam int RECIP      = (2 ** RECIP_SH + TILE_PX - 1) / TILE_PX;
  localparam int DIV_W      = XY_W + RECIP_SH + 1;

  // Offset within a tile to trit index: divide by the trit width.
  localparam int RECIP2_SH  = PX_W + 3;
  localparam int RECIP2     = (2 ** RECIP2_SH + TRIT_PIXELS - 1) / TRIT_PIXELS;
  localparam int DIV2_W     = PX_W + RECIP2_SH + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PAT_WR  = 2'd0,
    CMD_GRID_WR = 2'd1,
    CMD_PAL_WR  = 2'd2,
    CMD_FETCH   = 2'd3
  } cmd_t;

  // Trit code read as zero.
  localparam logic [1:0] TRIT_CODE_BAD  = 2'd3;
  localparam logic [1:0] TRIT_CODE_ZERO = 2'd1;

  // Word handed from the address front end to the store stages.
  typedef struct packed {
    cmd_t                  cmd;
    logic                  blank;
    logic [GRID_AW-1:0]    cell_addr;
    logic [PX_W-1:0]       rem_x;
    logic [PX_W-1:0]       rem_y;
    logic                  pat_wen;
    logic [PAT_AW-1:0]     pat_waddr;
    logic [ROW_W-1:0]      row_trits;
    logic                  grid_wen;
    logic [GRID_AW-1:0]    grid_waddr;
    logic [CELL_DATA_W-1:0] grid_wdata;
    logic                  pal_wen;
    logic [PAL_AW-1:0]     pal_waddr;
    logic [COLOR_W-1:0]    pal_wdata;
  } item_t;

  // 27-step intensity ramp, padded to a power of two.
  localparam logic [CHAN_W-1:0] RAMP_LUT [32] = '{
    8'd0,   8'd10,  8'd20,  8'd29,  8'd39,  8'd49,  8'd59,  8'd69,
    8'd78,  8'd88,  8'd98,  8'd108, 8'd118, 8'd128, 8'd137, 8'd147,
    8'd157, 8'd167, 8'd177, 8'd186, 8'd196, 8'd206, 8'd216, 8'd226,
    8'd235, 8'd245, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  localparam logic signed [DIGIT_W:0] DMAX_S = (DIGIT_W + 1)'(DIGIT_MAX);

  // Saturate a signed digit to -13..13 and return it offset to 0..26.
  function automatic logic [DIGIT_W-1:0] dig_idx(input logic [DIGIT_W-1:0] d);
    logic signed [DIGIT_W:0] w;
    w = signed'({d[DIGIT_W-1], d});
    if (w < -DMAX_S) begin
      return '0;
    end else if (w > DMAX_S) begin
      return DIGIT_W'(2 * DIGIT_MAX);
    end else begin
      return DIGIT_W'(w + DMAX_S);
    end
  endfunction

  function automatic logic [CHAN_W-1:0] ramp_of(input logic [DIGIT_W-1:0] d);
    return RAMP_LUT[dig_idx(d)];
  endfunction

endpackage

>>> rtl/tpr_ram.sv
// Generic simple dual-port RAM with registered read.
module tpr_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tpr_front.sv
// Front end: input register, pixel to cell division and write decode.
module tpr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          take,
  input  logic [tpr_pkg::CMD_W-1:0]     in_cmd,
  input  logic [tpr_pkg::TILE_W-1:0]    in_tile_number,
  input  logic [tpr_pkg::PROW_W-1:0]    in_pattern_row,
  input  logic [tpr_pkg::ROW_W-1:0]     in_row_trits,
  input  logic [tpr_pkg::GRID_AW-1:0]   in_cell_index,
  input  logic [tpr_pkg::PAL_AW-1:0]    in_palette_slot,
  input  logic [tpr_pkg::DIGIT_W-1:0]   in_digit_high,
  input  logic [tpr_pkg::DIGIT_W-1:0]   in_digit_mid,
  input  logic [tpr_pkg::DIGIT_W-1:0]   in_digit_low,
  input  logic [tpr_pkg::XY_W-1:0]      in_pixel_x,
  input  logic [tpr_pkg::XY_W-1:0]      in_pixel_y,
  output logic                          s3_valid,
  output tpr_pkg::item_t                s3_item
);

  // Stage 1: captured word.
  logic                           s1_valid_r;
  tpr_pkg::cmd_t                  s1_cmd_r;
  logic [tpr_pkg::TILE_W-1:0]     s1_tile_r;
  logic [tpr_pkg::PROW_W-1:0]     s1_prow_r;
  logic [tpr_pkg::ROW_W-1:0]      s1_trits_r;
  logic [tpr_pkg::GRID_AW-1:0]    s1_cell_r;
  logic [tpr_pkg::PAL_AW-1:0]     s1_slot_r;
  logic [tpr_pkg::DIGIT_W-1:0]    s1_dh_r;
  logic [tpr_pkg::DIGIT_W-1:0]    s1_dm_r;
  logic [tpr_pkg::DIGIT_W-1:0]    s1_dl_r;
  logic [tpr_pkg::XY_W-1:0]       s1_x_r;
  logic [tpr_pkg::XY_W-1:0]       s1_y_r;

  // Stage 2: decoded writes and grid coordinates.
  logic                           s2_valid_r;
  tpr_pkg::item_t                 s2_item_r;
  tpr_pkg::item_t                 s2_item_nxt;
  logic [tpr_pkg::GX_W-1:0]       s2_gx_r;
  logic [tpr_pkg::GX_W-1:0]       s2_gy_r;
  logic [tpr_pkg::GX_W-1:0]       s2_gx_nxt;
  logic [tpr_pkg::GX_W-1:0]       s2_gy_nxt;
  logic [tpr_pkg::XY_W-1:0]       s2_x_r;
  logic [tpr_pkg::XY_W-1:0]       s2_y_r;

  // Stage 3: cell address and offsets within the tile.
  logic                           s3_valid_r;
  tpr_pkg::item_t                 s3_item_r;
  tpr_pkg::item_t                 s3_item_nxt;

  logic [tpr_pkg::DIV_W-1:0]      prod_x;
  logic [tpr_pkg::DIV_W-1:0]      prod_y;
  logic [tpr_pkg::CELL_W-1:0]     cell_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= take;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r   <= tpr_pkg::cmd_t'(in_cmd);
      s1_tile_r  <= in_tile_number;
      s1_prow_r  <= in_pattern_row;
      s1_trits_r <= in_row_trits;
      s1_cell_r  <= in_cell_index;
      s1_slot_r  <= in_palette_slot;
      s1_dh_r    <= in_digit_high;
      s1_dm_r    <= in_digit_mid;
      s1_dl_r    <= in_digit_low;
      s1_x_r     <= in_pixel_x;
      s1_y_r     <= in_pixel_y;
      s2_item_r  <= s2_item_nxt;
      s2_gx_r    <= s2_gx_nxt;
      s2_gy_r    <= s2_gy_nxt;
      s2_x_r     <= s1_x_r;
      s2_y_r     <= s1_y_r;
      s3_item_r  <= s3_item_nxt;
    end
  end

  // Divide the pixel position by the tile width: multiply by the
  // reciprocal, exact over the whole 9-bit range.
  assign prod_x    = tpr_pkg::DIV_W'(s1_x_r) * tpr_pkg::DIV_W'(tpr_pkg::RECIP);
  assign prod_y    = tpr_pkg::DIV_W'(s1_y_r) * tpr_pkg::DIV_W'(tpr_pkg::RECIP);
  assign s2_gx_nxt = prod_x[tpr_pkg::RECIP_SH +: tpr_pkg::GX_W];
  assign s2_gy_nxt = prod_y[tpr_pkg::RECIP_SH +: tpr_pkg::GX_W];

  always_comb begin
    s2_item_nxt            = '0;
    s2_item_nxt.cmd        = s1_cmd_r;
    s2_item_nxt.pat_wen    = (s1_cmd_r == tpr_pkg::CMD_PAT_WR) &&
                             (32'(s1_tile_r) < tpr_pkg::TILE_COUNT) &&
                             (32'(s1_prow_r) < tpr_pkg::TILE_ROWS);
    s2_item_nxt.pat_waddr  = tpr_pkg::PAT_AW'(s1_tile_r * tpr_pkg::TILE_ROWS) +
                             tpr_pkg::PAT_AW'(s1_prow_r);
    s2_item_nxt.row_trits  = s1_trits_r;
    // cell_index never reaches the store depth, only the screen size bounds it
    s2_item_nxt.grid_wen   = (s1_cmd_r == tpr_pkg::CMD_GRID_WR) &&
                             (32'(s1_cell_r) < tpr_pkg::GRID_CELLS);
    s2_item_nxt.grid_waddr = s1_cell_r;
    s2_item_nxt.grid_wdata = {s1_dh_r, s1_dm_r, s1_dl_r};
    s2_item_nxt.pal_wen    = (s1_cmd_r == tpr_pkg::CMD_PAL_WR) &&
                             (32'(s1_slot_r) < tpr_pkg::PAL_DEPTH);
    s2_item_nxt.pal_waddr  = s1_slot_r;
    s2_item_nxt.pal_wdata  = {tpr_pkg::ramp_of(s1_dh_r), tpr_pkg::ramp_of(s1_dm_r),
                              tpr_pkg::ramp_of(s1_dl_r)};
  end

  assign cell_full = tpr_pkg::CELL_W'(s2_gy_r * tpr_pkg::GRID_COLUMNS) +
                     tpr_pkg::CELL_W'(s2_gx_r);

  always_comb begin
    s3_item_nxt           = s2_item_r;
    s3_item_nxt.cell_addr = cell_full[tpr_pkg::GRID_AW-1:0];
    s3_item_nxt.blank     = !((32'(s2_gx_r) < tpr_pkg::GRID_COLUMNS) &&
                              (32'(s2_gy_r) < tpr_pkg::GRID_ROWS) &&
                              (32'(cell_full) < tpr_pkg::GRID_DEPTH));
    s3_item_nxt.rem_x     = tpr_pkg::PX_W'(s2_x_r -
                            tpr_pkg::XY_W'(s2_gx_r * tpr_pkg::TILE_PX));
    s3_item_nxt.rem_y     = tpr_pkg::PX_W'(s2_y_r -
                            tpr_pkg::XY_W'(s2_gy_r * tpr_pkg::TILE_PX));
  end

  assign s3_valid = s3_valid_r;
  assign s3_item  = s3_item_r;

endmodule

>>> rtl/ternary_tile_pixel_renderer.sv
// Top level of the ternary tile pixel renderer: store stages and output register.
// A fetch word passes the stage registers of stages 1 to 6 and the output register to out_*.
// Throughput: one word per cycle unless stalled; each store is read and written in its own stage.
// Stall: a stalled output freezes every stage and the RAM read registers together.
// Reset (rst_n low, synchronous) empties the pipeline, then a clearing pass sets
// every pattern row to zero trits and grid and palette to zero.
// in_stall stays high for the whole clearing pass.
module ternary_tile_pixel_renderer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tpr_pkg::CMD_W-1:0]     in_cmd,
  input  logic [tpr_pkg::TILE_W-1:0]    in_tile_number,
  input  logic [tpr_pkg::PROW_W-1:0]    in_pattern_row,
  input  logic [tpr_pkg::ROW_W-1:0]     in_row_trits,
  input  logic [tpr_pkg::GRID_AW-1:0]   in_cell_index,
  input  logic [tpr_pkg::PAL_AW-1:0]    in_palette_slot,
  input  logic [tpr_pkg::DIGIT_W-1:0]   in_digit_high,
  input  logic [tpr_pkg::DIGIT_W-1:0]   in_digit_mid,
  input  logic [tpr_pkg::DIGIT_W-1:0]   in_digit_low,
  input  logic [tpr_pkg::XY_W-1:0]      in_pixel_x,
  input  logic [tpr_pkg::XY_W-1:0]      in_pixel_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tpr_pkg::CHAN_W-1:0]    out_red,
  output logic [tpr_pkg::CHAN_W-1:0]    out_green,
  output logic [tpr_pkg::CHAN_W-1:0]    out_blue
);

  // Pipeline moves as one: advance unless a result sits unaccepted.
  logic adv;
  logic take;

  // Clearing pass after reset.
  logic                        clr_r;
  logic                        clr_nxt;
  logic [tpr_pkg::PAT_AW-1:0]  clr_cnt_r;
  logic [tpr_pkg::PAT_AW-1:0]  clr_cnt_nxt;

  // Stage 3, from the front end: grid store access.
  logic                        s3_valid;
  tpr_pkg::item_t              s3_item;
  logic [tpr_pkg::DIV2_W-1:0]  prod_col;
  logic [tpr_pkg::DIV2_W-1:0]  prod_row;

  // Stage 4: pattern store access.
  logic                           s4_valid_r;
  tpr_pkg::cmd_t                  s4_cmd_r;
  logic                           s4_blank_r;
  logic [tpr_pkg::TRIT_IDX_W-1:0] s4_trow_r;
  logic [tpr_pkg::TRIT_IDX_W-1:0] s4_tcol_r;
  logic                           s4_pat_wen_r;
  logic [tpr_pkg::PAT_AW-1:0]     s4_pat_waddr_r;
  logic [tpr_pkg::ROW_W-1:0]      s4_trits_r;
  logic                           s4_pal_wen_r;
  logic [tpr_pkg::PAL_AW-1:0]     s4_pal_waddr_r;
  logic [tpr_pkg::COLOR_W-1:0]    s4_pal_wdata_r;
  logic [tpr_pkg::CELL_DATA_W-1:0] grid_rdata;
  logic [tpr_pkg::DIGIT_W-1:0]    s4_pal_idx;
  logic [tpr_pkg::DIGIT_W-1:0]    s4_mid_idx;
  logic [tpr_pkg::DIGIT_W-1:0]    s4_low_idx;
  logic [tpr_pkg::PAT_AW-1:0]     s4_pat_raddr;

  // Stage 5: palette store access.
  logic                           s5_valid_r;
  tpr_pkg::cmd_t                  s5_cmd_r;
  logic                           s5_blank_r;
  logic [tpr_pkg::TRIT_IDX_W-1:0] s5_tcol_r;
  logic [tpr_pkg::DIGIT_W-1:0]    s5_pal_idx_r;
  logic                           s5_pal_wen_r;
  logic [tpr_pkg::PAL_AW-1:0]     s5_pal_waddr_r;
  logic [tpr_pkg::COLOR_W-1:0]    s5_pal_wdata_r;
  logic [tpr_pkg::ROW_W-1:0]      pat_rdata;
  logic [tpr_pkg::TRIT_IDX_W-1:0] s5_tsel;
  logic [1:0]                     s5_code_raw;
  logic [1:0]                     s5_code;
  logic [tpr_pkg::PAL_AW-1:0]     s5_pal_raddr;

  // Stage 6: palette data lands.
  logic                           s6_valid_r;
  tpr_pkg::cmd_t                  s6_cmd_r;
  logic                           s6_blank_r;
  logic [tpr_pkg::COLOR_W-1:0]    pal_rdata;

  // Output register.
  logic                           out_valid_r;
  logic [tpr_pkg::COLOR_W-1:0]    out_color_r;

  // RAM port controls.
  logic                           grid_we;
  logic [tpr_pkg::GRID_AW-1:0]    grid_waddr;
  logic [tpr_pkg::CELL_DATA_W-1:0] grid_wdata;
  logic                           pat_we;
  logic [tpr_pkg::PAT_AW-1:0]     pat_waddr;
  logic [tpr_pkg::ROW_W-1:0]      pat_wdata;
  logic                           pal_we;
  logic [tpr_pkg::PAL_AW-1:0]     pal_waddr;
  logic [tpr_pkg::COLOR_W-1:0]    pal_wdata;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = clr_r || !adv;
  assign take     = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Clearing pass: one address per cycle over the deepest store; the shallower
  // stores drop out once the count passes their depth.
  // ---------------------------------------------------------------------------
  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (32'(clr_cnt_r) == tpr_pkg::PAT_DEPTH - 1) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1 to 3: input capture, pixel to cell, write decode.
  // ---------------------------------------------------------------------------
  tpr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .take            (take),
    .in_cmd          (in_cmd),
    .in_tile_number  (in_tile_number),
    .in_pattern_row  (in_pattern_row),
    .in_row_trits    (in_row_trits),
    .in_cell_index   (in_cell_index),
    .in_palette_slot (in_palette_slot),
    .in_digit_high   (in_digit_high),
    .in_digit_mid    (in_digit_mid),
    .in_digit_low    (in_digit_low),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .s3_valid        (s3_valid),
    .s3_item         (s3_item)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: grid store. Writes land here, in order with the fetch reads, so a
  // fetch always sees every earlier grid write.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (clr_r) begin
      grid_we    = 32'(clr_cnt_r) < tpr_pkg::GRID_DEPTH;
      grid_waddr = clr_cnt_r[tpr_pkg::GRID_AW-1:0];
      grid_wdata = '0;
    end else begin
      grid_we    = adv && s3_valid && s3_item.grid_wen;
      grid_waddr = s3_item.grid_waddr;
      grid_wdata = s3_item.grid_wdata;
    end
  end

  tpr_ram #(
    .WIDTH (tpr_pkg::CELL_DATA_W),
    .DEPTH (tpr_pkg::GRID_DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .re    (adv),
    .raddr (s3_item.cell_addr),
    .rdata (grid_rdata)
  );

  // Offset within the tile to trit row and column (divide by trit width).
  assign prod_col = tpr_pkg::DIV2_W'(s3_item.rem_x) * tpr_pkg::DIV2_W'(tpr_pkg::RECIP2);
  assign prod_row = tpr_pkg::DIV2_W'(s3_item.rem_y) * tpr_pkg::DIV2_W'(tpr_pkg::RECIP2);

  // ---------------------------------------------------------------------------
  // Stage 4: pattern store. Tile = 27 * mid + low after offsetting both digits.
  // ---------------------------------------------------------------------------
  assign s4_pal_idx   = tpr_pkg::dig_idx(grid_rdata[2*tpr_pkg::DIGIT_W +: tpr_pkg::DIGIT_W]);
  assign s4_mid_idx   = tpr_pkg::dig_idx(grid_rdata[tpr_pkg::DIGIT_W +: tpr_pkg::DIGIT_W]);
  assign s4_low_idx   = tpr_pkg::dig_idx(grid_rdata[0 +: tpr_pkg::DIGIT_W]);
  assign s4_pat_raddr = tpr_pkg::PAT_AW'(s4_mid_idx * tpr_pkg::PAT_MID_STEP) +
                        tpr_pkg::PAT_AW'(s4_low_idx * tpr_pkg::TILE_ROWS) +
                        tpr_pkg::PAT_AW'(s4_trow_r);

  always_comb begin
    if (clr_r) begin
      pat_we    = 1'b1;
      pat_waddr = clr_cnt_r;
      pat_wdata = tpr_pkg::ROW_ALL_ZERO;
    end else begin
      pat_we    = adv && s4_valid_r && s4_pat_wen_r;
      pat_waddr = s4_pat_waddr_r;
      pat_wdata = s4_trits_r;
    end
  end

  tpr_ram #(
    .WIDTH (tpr_pkg::ROW_W),
    .DEPTH (tpr_pkg::PAT_DEPTH)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .re    (adv),
    .raddr (s4_pat_raddr),
    .rdata (pat_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: pick the trit, read code three as zero, then the palette store.
  // Trit column counts from the left, so bit pair 8 - col.
  // ---------------------------------------------------------------------------
  assign s5_tsel     = tpr_pkg::TRIT_IDX_W'(tpr_pkg::TILE_TRITS - 1) - s5_tcol_r;
  assign s5_code_raw = pat_rdata[{s5_tsel, 1'b0} +: 2];
  assign s5_code     = (s5_code_raw == tpr_pkg::TRIT_CODE_BAD) ? tpr_pkg::TRIT_CODE_ZERO
                                                                : s5_code_raw;
  assign s5_pal_raddr = tpr_pkg::PAL_AW'(s5_pal_idx_r * tpr_pkg::PAL_TRITS) +
                        tpr_pkg::PAL_AW'(s5_code);

  always_comb begin
    if (clr_r) begin
      pal_we    = 32'(clr_cnt_r) < tpr_pkg::PAL_DEPTH;
      pal_waddr = clr_cnt_r[tpr_pkg::PAL_AW-1:0];
      pal_wdata = '0;
    end else begin
      pal_we    = adv && s5_valid_r && s5_pal_wen_r;
      pal_waddr = s5_pal_waddr_r;
      pal_wdata = s5_pal_wdata_r;
    end
  end

  tpr_ram #(
    .WIDTH (tpr_pkg::COLOR_W),
    .DEPTH (tpr_pkg::PAL_DEPTH)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (adv),
    .raddr (s5_pal_raddr),
    .rdata (pal_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage registers. Valid bits reset; payload just follows.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r  <= s3_valid;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      // drop write words here: only fetches produce a result
      out_valid_r <= s6_valid_r && (s6_cmd_r == tpr_pkg::CMD_FETCH);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_cmd_r       <= s3_item.cmd;
      s4_blank_r     <= s3_item.blank;
      s4_trow_r      <= prod_row[tpr_pkg::RECIP2_SH +: tpr_pkg::TRIT_IDX_W];
      s4_tcol_r      <= prod_col[tpr_pkg::RECIP2_SH +: tpr_pkg::TRIT_IDX_W];
      s4_pat_wen_r   <= s3_item.pat_wen;
      s4_pat_waddr_r <= s3_item.pat_waddr;
      s4_trits_r     <= s3_item.row_trits;
      s4_pal_wen_r   <= s3_item.pal_wen;
      s4_pal_waddr_r <= s3_item.pal_waddr;
      s4_pal_wdata_r <= s3_item.pal_wdata;

      s5_cmd_r       <= s4_cmd_r;
      s5_blank_r     <= s4_blank_r;
      s5_tcol_r      <= s4_tcol_r;
      s5_pal_idx_r   <= s4_pal_idx;
      s5_pal_wen_r   <= s4_pal_wen_r;
      s5_pal_waddr_r <= s4_pal_waddr_r;
      s5_pal_wdata_r <= s4_pal_wdata_r;

      s6_cmd_r       <= s5_cmd_r;
      s6_blank_r     <= s5_blank_r;

      // pixels off the screen come out black
      out_color_r    <= s6_blank_r ? '0 : pal_rdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_color_r[2*tpr_pkg::CHAN_W +: tpr_pkg::CHAN_W];
  assign out_green = out_color_r[tpr_pkg::CHAN_W +: tpr_pkg::CHAN_W];
  assign out_blue  = out_color_r[0 +: tpr_pkg::CHAN_W];

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The pipeline holds no word while the clearing pass owns the store ports.
  a_clear_empty : assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !(s3_valid || s4_valid_r || s5_valid_r || s6_valid_r || out_valid_r))
    else $error("word in flight during clearing pass");

  // An off-screen fetch leaves the pipe as a black pixel.
  a_blank_black : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s6_valid_r && (s6_cmd_r == tpr_pkg::CMD_FETCH) && s6_blank_r) |=>
    (out_valid && (out_red == '0) && (out_green == '0) && (out_blue == '0)))
    else $error("off-screen fetch not black");

  // A held pipeline keeps its stage 5 and stage 6 valids and the palette read data.
  a_hold_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(s5_valid_r) && $stable(s6_valid_r) && $stable(pal_rdata)))
    else $error("stage moved during stall");

endmodule
